// ===== rtl/grid_zone_emergency_detector_core_assert.svh =====
// Assertion macros shared by the grid zone emergency detector RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef GRID_ZONE_EMERGENCY_DETECTOR_CORE_ASSERT_SVH
`define GRID_ZONE_EMERGENCY_DETECTOR_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define GZED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define GZED_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/gzed_pkg.sv =====
// Package for the grid zone emergency detector: types, constants and the zone test.
// Used by the timer module and the top level; depends on nothing.
package gzed_pkg;

    localparam int CountW = 21;
    localparam int TimerW = 22;
    localparam logic [CountW-1:0] HITS_MAX = {CountW{1'b1}};
    localparam logic [7:0] CELL_OCCUPIED = 8'd255;
    localparam logic [31:0] ANCHOR_RESET = 32'd33489408;

    typedef enum logic [2:0] {
        REG_ANCHOR    = 3'd0,
        REG_CLOSE     = 3'd1,
        REG_EMG       = 3'd2,
        REG_PROTECT   = 3'd3,
        REG_EMG_COUNT = 3'd4,
        REG_EMG_TIME  = 3'd5,
        REG_CL_COUNT  = 3'd6,
        REG_CL_TIME   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SLOW   = 2'd1,
        MODE_STOP   = 2'd2
    } mode_t;

    typedef struct packed {
        logic close_hit;
        logic emg_hit;
        logic prot_hit;
    } zone_hit_t;

    typedef struct packed {
        logic step;
        logic over;
    } tmr_ctrl_t;

    // The rectangle spans columns [centre - half, centre + half) and rows
    // [bottom - height, bottom). The signed bounds are rearranged into
    // unsigned sums so that no negative value arises.
    function automatic logic in_zone(input logic [9:0] col, input logic [9:0] row,
                                     input logic [31:0] anchor, input logic [31:0] zone);
        logic [16:0] col_plus_half;
        logic [16:0] centre_plus_half;
        logic [16:0] row_plus_height;
        col_plus_half    = 17'(col) + 17'(zone[15:0]);
        centre_plus_half = 17'(anchor[15:0]) + 17'(zone[15:0]);
        row_plus_height  = 17'(row) + 17'(zone[31:16]);
        return (col_plus_half >= 17'(anchor[15:0])) && (17'(col) < centre_plus_half) &&
               (row_plus_height >= 17'(anchor[31:16])) && (16'(row) < anchor[31:16]);
    endfunction

endpackage

// ===== rtl/gzed_if.sv =====
// Stream interfaces of the grid zone emergency detector: grid cells in, modes out.
// Each carries valid, ready and its payload; no dependencies.
interface gzed_cell_if;
    logic       valid;
    logic       ready;
    logic [9:0] cell_col;
    logic [9:0] cell_row;
    logic [7:0] cell_value;
    logic       frame_end;

    modport source (output valid, output cell_col, output cell_row, output cell_value,
                    output frame_end, input ready);
    modport sink (input valid, input cell_col, input cell_row, input cell_value,
                  input frame_end, output ready);
endinterface

interface gzed_mode_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;

    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

// ===== rtl/gzed_timer.sv =====
// Persistence timer: rises while a zone count is over its limit, falls otherwise.
// Depends on gzed_pkg for widths and the control struct.
module gzed_timer
    import gzed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tmr_ctrl_t         ctrl,
    input  logic [CountW-1:0] count_limit,
    input  logic [TimerW-1:0] time_limit,
    output logic              reached
);

    logic [TimerW-1:0] timer_reg;
    logic [TimerW-1:0] timer_next;
    logic [TimerW-1:0] rise_cap;

    // The rise stops at twice the count limit; a timer already above it holds.
    assign rise_cap = {count_limit, 1'b0};

    always_comb
    begin
        timer_next = timer_reg;
        if (ctrl.over)
        begin
            if (timer_reg < rise_cap)
            begin
                timer_next = timer_reg + TimerW'(1);
            end
        end
        else if (timer_reg != '0)
        begin
            timer_next = timer_reg - TimerW'(1);
        end
    end

    assign reached = (timer_next >= time_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else if (ctrl.step)
        begin
            timer_reg <= timer_next;
        end
    end

endmodule

// ===== rtl/grid_zone_emergency_detector_core.sv =====
// A mode beat is registered in the output register after the frame-end cell passes stages one, two and three.
// Throughput: one grid cell per cycle unless a frame-end cell waits on an untaken mode beat;
// three pipeline stages and an output register absorb other cells while a beat waits to be taken.
// Reset clears every valid flag, the per-frame counts, the stop flag, both timers and
// loads the configuration registers with their reset values.
// Depends on gzed_pkg, gzed_if, gzed_timer and the assertion macro header.
`include "grid_zone_emergency_detector_core_assert.svh"

module grid_zone_emergency_detector_core
    import gzed_pkg::*;
#(
    parameter int GRID_SIDE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    gzed_cell_if.sink   grid,
    gzed_mode_if.source alert,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [31:0]       anchor_reg;
    logic [31:0]       close_zone_reg;
    logic [31:0]       emg_zone_reg;
    logic [31:0]       prot_zone_reg;
    logic [CountW-1:0] emg_count_lim_reg;
    logic [TimerW-1:0] emg_time_lim_reg;
    logic [CountW-1:0] cl_count_lim_reg;
    logic [TimerW-1:0] cl_time_lim_reg;

    // Pipeline registers.
    logic              s1_valid_reg;
    logic [9:0]        s1_col_reg;
    logic [9:0]        s1_row_reg;
    logic [7:0]        s1_value_reg;
    logic              s1_last_reg;
    logic              s2_valid_reg;
    zone_hit_t         s2_hit_reg;
    logic              s2_last_reg;
    logic              s3_valid_reg;
    logic              s3_last_reg;
    logic              s3_stop_reg;
    logic              s3_emg_over_reg;
    logic              s3_cl_over_reg;
    logic              out_valid_reg;
    mode_t             out_mode_reg;

    // Per-frame state.
    logic [CountW-1:0] close_hits_reg;
    logic [CountW-1:0] emergency_hits_reg;
    logic              stop_seen_reg;
    logic [CountW-1:0] close_hits_next;
    logic [CountW-1:0] emergency_hits_next;

    logic              in_fire;
    logic              out_free;
    logic              s3_fire;
    logic              s3_free;
    logic              s2_fire;
    logic              s2_free;
    logic              s1_fire;
    logic              s1_free;
    logic              on_grid;
    logic              occupied_close;
    zone_hit_t         s1_hit;
    tmr_ctrl_t         emg_ctrl;
    tmr_ctrl_t         cl_ctrl;
    logic              emg_reached;
    logic              cl_reached;
    mode_t             mode_next;

    // Handshake chain: each stage moves when the stage after it has room.
    assign out_free   = !out_valid_reg || alert.ready;
    assign s3_fire    = s3_valid_reg && (!s3_last_reg || out_free);
    assign s3_free    = !s3_valid_reg || s3_fire;
    assign s2_fire    = s2_valid_reg && s3_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_fire    = s1_valid_reg && s2_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign grid.ready = s1_free;
    assign in_fire    = grid.valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg        <= ANCHOR_RESET;
            close_zone_reg    <= '0;
            emg_zone_reg      <= '0;
            prot_zone_reg     <= '0;
            emg_count_lim_reg <= '0;
            emg_time_lim_reg  <= '0;
            cl_count_lim_reg  <= '0;
            cl_time_lim_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_ANCHOR:    anchor_reg        <= cfg_data;
                REG_CLOSE:     close_zone_reg    <= cfg_data;
                REG_EMG:       emg_zone_reg      <= cfg_data;
                REG_PROTECT:   prot_zone_reg     <= cfg_data;
                REG_EMG_COUNT: emg_count_lim_reg <= cfg_data[CountW-1:0];
                REG_EMG_TIME:  emg_time_lim_reg  <= cfg_data[TimerW-1:0];
                REG_CL_COUNT:  cl_count_lim_reg  <= cfg_data[CountW-1:0];
                REG_CL_TIME:   cl_time_lim_reg   <= cfg_data[TimerW-1:0];
                default:       anchor_reg        <= anchor_reg;
            endcase
        end
    end

    // Stage one to two: zone tests on the registered cell.
    assign on_grid = ({22'd0, s1_col_reg} < 32'(GRID_SIDE)) &&
                     ({22'd0, s1_row_reg} < 32'(GRID_SIDE));
    assign occupied_close = on_grid && (s1_value_reg == CELL_OCCUPIED) &&
                            in_zone(s1_col_reg, s1_row_reg, anchor_reg, close_zone_reg);

    always_comb
    begin
        s1_hit.close_hit = occupied_close;
        s1_hit.emg_hit   = occupied_close &&
                           in_zone(s1_col_reg, s1_row_reg, anchor_reg, emg_zone_reg);
        s1_hit.prot_hit  = occupied_close &&
                           in_zone(s1_col_reg, s1_row_reg, anchor_reg, prot_zone_reg);
    end

    // Stage two to three: saturating hit counts and the frame-end comparisons.
    assign close_hits_next = (s2_hit_reg.close_hit && (close_hits_reg != HITS_MAX)) ?
                             close_hits_reg + CountW'(1) : close_hits_reg;
    assign emergency_hits_next = (s2_hit_reg.emg_hit && (emergency_hits_reg != HITS_MAX)) ?
                                 emergency_hits_reg + CountW'(1) : emergency_hits_reg;

    // Stage three to output: timers and the mode decision.
    always_comb
    begin
        emg_ctrl.step = s3_fire && s3_last_reg && !s3_stop_reg;
        emg_ctrl.over = s3_emg_over_reg;
        cl_ctrl.step  = s3_fire && s3_last_reg && !s3_stop_reg;
        cl_ctrl.over  = s3_cl_over_reg;
    end

    gzed_timer u_emg_timer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (emg_ctrl),
        .count_limit (emg_count_lim_reg),
        .time_limit  (emg_time_lim_reg),
        .reached     (emg_reached)
    );

    gzed_timer u_close_timer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cl_ctrl),
        .count_limit (cl_count_lim_reg),
        .time_limit  (cl_time_lim_reg),
        .reached     (cl_reached)
    );

    always_comb
    begin
        if (s3_stop_reg || emg_reached)
        begin
            mode_next = MODE_STOP;
        end
        else if (cl_reached)
        begin
            mode_next = MODE_SLOW;
        end
        else
        begin
            mode_next = MODE_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            close_hits_reg     <= '0;
            emergency_hits_reg <= '0;
            stop_seen_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                s3_valid_reg <= 1'b1;
                if (s2_last_reg)
                begin
                    close_hits_reg     <= '0;
                    emergency_hits_reg <= '0;
                    stop_seen_reg      <= 1'b0;
                end
                else
                begin
                    close_hits_reg     <= close_hits_next;
                    emergency_hits_reg <= emergency_hits_next;
                    stop_seen_reg      <= stop_seen_reg || s2_hit_reg.prot_hit;
                end
            end
            else if (s3_fire)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_fire && s3_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (alert.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg   <= grid.cell_col;
            s1_row_reg   <= grid.cell_row;
            s1_value_reg <= grid.cell_value;
            s1_last_reg  <= grid.frame_end;
        end
        if (s1_fire)
        begin
            s2_hit_reg  <= s1_hit;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_fire)
        begin
            s3_last_reg     <= s2_last_reg;
            s3_stop_reg     <= stop_seen_reg || s2_hit_reg.prot_hit;
            s3_emg_over_reg <= (emergency_hits_next > emg_count_lim_reg);
            s3_cl_over_reg  <= (close_hits_next > cl_count_lim_reg);
        end
        if (s3_fire && s3_last_reg)
        begin
            out_mode_reg <= mode_next;
        end
    end

    assign alert.valid = out_valid_reg;
    assign alert.mode  = out_mode_reg;

    `GZED_ASSERT(a_emg_within_close, emergency_hits_reg <= close_hits_reg, "Emergency count exceeds close count.")
    `GZED_ASSERT_NEXT(a_frame_clears, s2_fire && s2_last_reg, (close_hits_reg == '0) && (emergency_hits_reg == '0) && !stop_seen_reg, "Per-frame state not cleared at frame end.")
    `GZED_ASSERT_NEXT(a_stop_mode, s3_fire && s3_last_reg && s3_stop_reg, out_valid_reg && (out_mode_reg == MODE_STOP), "Stop flag did not give an emergency stop beat.")
    `GZED_ASSERT_NEXT(a_frame_beat, s3_fire && s3_last_reg, out_valid_reg, "Frame end did not produce a mode beat.")

endmodule
